[rtl/piecewise_linear_rgba_transfer_unit_defines.svh]
// Assertion macros for the piecewise-linear RGBA transfer unit.
// Included by the files that carry concurrent assertions; needs no other file.
// Define ASSERT_OFF to compile the checks away.
`ifndef PIECEWISE_LINEAR_RGBA_TRANSFER_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_RGBA_TRANSFER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PLRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PLRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PLRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PLRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/plrt_pkg.sv]
// Shared types and constants of the piecewise-linear RGBA transfer unit.
// Used by the cell, lane and top-level modules; depends on nothing.
package plrt_pkg;

	localparam int MAX_POINTS    = 8;
	localparam int POSITION_BITS = 12;
	localparam int INDEX_BITS    = 3;
	localparam int COUNT_BITS    = 4;
	localparam int COMP_BITS     = 8;
	localparam int NUM_COMP      = 4;
	localparam int POS_BITS      = POSITION_BITS + 1;
	localparam int DIFF_BITS     = COMP_BITS + 1;
	localparam int OFF_BITS      = POS_BITS + 1;
	localparam int PROD_BITS     = DIFF_BITS + OFF_BITS;
	localparam int QUO_BITS      = PROD_BITS - 2;
	localparam int DIV_CNT_BITS  = $clog2(QUO_BITS);

	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1 << POSITION_BITS);

	localparam int COMP_RED   = 0;
	localparam int COMP_GREEN = 1;
	localparam int COMP_BLUE  = 2;
	localparam int COMP_ALPHA = 3;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic [POS_BITS-1:0]                 pos;
		logic [NUM_COMP-1:0][COMP_BITS-1:0]  comp;
	} point_t;

	typedef struct packed {
		logic                      valid;
		logic [POSITION_BITS-1:0]  x;
		logic [COUNT_BITS-1:0]     left;
		logic                      found;
		logic                      has_prev;
		point_t                    prev;
		point_t                    lo;
		point_t                    hi;
	} query_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic init;
		logic step;
	} lane_ctrl_t;

	typedef struct packed {
		logic [3:0]                pad;
		logic [POSITION_BITS-1:0]  sample_position;
		logic [COMP_BITS-1:0]      point_blue;
		logic [COMP_BITS-1:0]      point_green;
		logic [COMP_BITS-1:0]      point_red;
		logic [COMP_BITS-1:0]      point_alpha;
		logic [POS_BITS-1:0]       point_position;
		logic [INDEX_BITS-1:0]     point_index;
	} in_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_INIT,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

[rtl/piecewise_linear_rgba_transfer_unit.sv]
// Piecewise-linear RGBA transfer unit. A write beat stores a control point in one
// cell of an eight-cell chain. A sample beat walks the chain, one cell per cycle,
// then four color lanes divide serially one quotient bit per cycle. No new beat is
// taken until the sample has passed the chain and the 21-step divider and its
// result is loaded into the output register; there it waits, so a new beat is
// accepted while the result is still held. Depends on plrt_pkg, plrt_cell,
// plrt_lane and the assertion macro header.
`include "piecewise_linear_rgba_transfer_unit_defines.svh"

module piecewise_linear_rgba_transfer_unit
	import plrt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// From bit 0: point_index, point_position, point_alpha, point_red, point_green,
	// point_blue, sample_position, zero padding.
	input  logic [63:0]            s_tdata,
	// Bit 0: op.
	input  logic [0:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// From bit 0: out_red, out_green, out_blue, out_alpha.
	output logic [31:0]            m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [COUNT_BITS-1:0]  cfg_data
);

	in_beat_t                           beat;
	state_t                             state_q;
	state_t                             state_d;
	logic [COUNT_BITS-1:0]              count_q;
	logic [DIV_CNT_BITS-1:0]            div_cnt_q;
	logic                               empty_q;
	logic                               m_tvalid_q;
	logic [NUM_COMP-1:0][COMP_BITS-1:0] out_q;
	logic [NUM_COMP-1:0][COMP_BITS-1:0] lane_res;
	lane_ctrl_t                         lane_ctrl;
	logic                               out_load;
	logic                               in_acc;
	logic                               smp_acc;
	logic [MAX_POINTS-1:0]              wr_sel;
	point_t                             wr_pt;
	query_t                             qry_head;
	query_t                             qry [MAX_POINTS+1];
	query_t                             qry_end;
	point_t                             lo_pt;
	point_t                             hi_pt;
	logic                               chain_busy;

	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(QUO_BITS - 1);

	assign beat      = in_beat_t'(s_tdata);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign smp_acc   = in_acc && (s_tuser[0] == OP_SAMPLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;

	always_comb begin
		wr_pt.pos              = beat.point_position;
		wr_pt.comp[COMP_RED]   = beat.point_red;
		wr_pt.comp[COMP_GREEN] = beat.point_green;
		wr_pt.comp[COMP_BLUE]  = beat.point_blue;
		wr_pt.comp[COMP_ALPHA] = beat.point_alpha;
		for (int i = 0; i < MAX_POINTS; i++) begin
			wr_sel[i] = in_acc && (s_tuser[0] == OP_WRITE)
				&& (beat.point_index == INDEX_BITS'(i));
		end
	end

	always_comb begin
		qry_head          = '0;
		qry_head.valid    = smp_acc;
		qry_head.x        = beat.sample_position;
		qry_head.left     = count_q;
	end

	assign qry[0] = qry_head;

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		plrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_sel[g]),
			.wr_point (wr_pt),
			.qry_in   (qry[g]),
			.qry_out  (qry[g+1])
		);
	end

	assign qry_end = qry[MAX_POINTS];

	always_comb begin
		chain_busy = 1'b0;
		for (int i = 1; i <= MAX_POINTS; i++) begin
			chain_busy = chain_busy | qry[i].valid;
		end
	end

	always_comb begin
		if (qry_end.found) begin
			lo_pt = qry_end.lo;
			hi_pt = qry_end.hi;
		end else begin
			lo_pt                  = qry_end.prev;
			hi_pt                  = qry_end.prev;
			hi_pt.pos              = POS_ONE;
			hi_pt.comp[COMP_ALPHA] = '0;
		end
	end

	for (genvar j = 0; j < NUM_COMP; j++) begin : g_lane
		plrt_lane u_lane (
			.clk    (clk),
			.ctrl   (lane_ctrl),
			.a      (lo_pt.comp[j]),
			.b      (hi_pt.comp[j]),
			.lo_pos (lo_pt.pos),
			.hi_pos (hi_pt.pos),
			.x      (qry_end.x),
			.res    (lane_res[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		lane_ctrl = '0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (smp_acc) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (qry_end.valid) begin
					lane_ctrl.load = 1'b1;
					state_d        = ST_MUL;
				end
			end
			ST_MUL: begin
				lane_ctrl.mul = 1'b1;
				state_d       = ST_INIT;
			end
			ST_INIT: begin
				lane_ctrl.init = 1'b1;
				state_d        = ST_DIV;
			end
			ST_DIV: begin
				lane_ctrl.step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= (cfg_data > COUNT_BITS'(MAX_POINTS)) ?
					COUNT_BITS'(MAX_POINTS) : cfg_data;
			end
			if (lane_ctrl.init) begin
				div_cnt_q <= '0;
			end else if (lane_ctrl.step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lane_ctrl.load) begin
			empty_q <= !qry_end.has_prev;
		end
		if (out_load) begin
			out_q <= empty_q ? '0 : lane_res;
		end
	end

	`PLRT_ASSERT_IMPLY(a_idle_chain_empty, clk, arst_n, state_q == ST_IDLE, !chain_busy, "query left in chain while idle")
	`PLRT_ASSERT_NEXT(a_sample_starts_search, clk, arst_n, smp_acc, state_q == ST_SEARCH, "accepted sample did not start a search")
	`PLRT_ASSERT_NEXT(a_div_ends, clk, arst_n, (state_q == ST_DIV) && (div_cnt_q == DIV_LAST), state_q == ST_FIN, "divider did not finish on its last step")
	`PLRT_ASSERT_IMPLY(a_count_range, clk, arst_n, 1'b1, count_q <= COUNT_BITS'(MAX_POINTS), "point count above table depth")

endmodule

[rtl/plrt_cell.sv]
// One cell of the control point chain: holds one point and passes the search query on.
// Depends on plrt_pkg.
module plrt_cell
	import plrt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  point_t wr_point,
	input  query_t qry_in,
	output query_t qry_out
);

	point_t pt_q;
	query_t qry_d;
	query_t qry_q;
	logic   vld_q;
	point_t implicit_lo;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pt_q <= wr_point;
		end
	end

	always_comb begin
		implicit_lo                  = pt_q;
		implicit_lo.pos              = '0;
		implicit_lo.comp[COMP_ALPHA] = '0;
		qry_d = qry_in;
		if (qry_in.valid && (qry_in.left != '0)) begin
			qry_d.left = qry_in.left - COUNT_BITS'(1);
			if (!qry_in.found && (pt_q.pos > {1'b0, qry_in.x})) begin
				qry_d.found = 1'b1;
				qry_d.hi    = pt_q;
				qry_d.lo    = qry_in.has_prev ? qry_in.prev : implicit_lo;
			end
			qry_d.prev     = pt_q;
			qry_d.has_prev = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		qry_q <= qry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= qry_in.valid;
		end
	end

	always_comb begin
		qry_out       = qry_q;
		qry_out.valid = vld_q;
	end

endmodule

[rtl/plrt_lane.sv]
// One color lane: difference, product, serial restoring divide and saturation.
// Depends on plrt_pkg; sequenced by the top level through lane_ctrl_t.
module plrt_lane
	import plrt_pkg::*;
(
	input  logic                      clk,
	input  lane_ctrl_t                ctrl,
	input  logic [COMP_BITS-1:0]      a,
	input  logic [COMP_BITS-1:0]      b,
	input  logic [POS_BITS-1:0]       lo_pos,
	input  logic [POS_BITS-1:0]       hi_pos,
	input  logic [POSITION_BITS-1:0]  x,
	output logic [COMP_BITS-1:0]      res
);

	logic [COMP_BITS-1:0]         a_q;
	logic signed [DIFF_BITS-1:0]  diff_s1;
	logic signed [OFF_BITS-1:0]   off_s1;
	logic signed [OFF_BITS-1:0]   span_s1;
	logic signed [PROD_BITS-1:0]  prod_s2;
	logic [QUO_BITS-1:0]          quo_q;
	logic [POS_BITS-1:0]          rem_q;
	logic [POS_BITS-1:0]          dvs_q;
	logic                         neg_q;
	logic                         zero_q;

	logic signed [PROD_BITS-1:0]  prod_abs;
	logic signed [OFF_BITS-1:0]   span_abs;
	logic [POS_BITS:0]            trial;
	logic [POS_BITS:0]            trial_sub;
	logic                         ge;
	logic signed [PROD_BITS-1:0]  q_ext;
	logic signed [PROD_BITS-1:0]  q_sgn;
	logic signed [PROD_BITS-1:0]  sum;

	always_comb begin
		prod_abs  = prod_s2[PROD_BITS-1] ? -prod_s2 : prod_s2;
		span_abs  = span_s1[OFF_BITS-1] ? -span_s1 : span_s1;
		trial     = {rem_q, quo_q[QUO_BITS-1]};
		trial_sub = trial - {1'b0, dvs_q};
		ge        = trial >= {1'b0, dvs_q};
		q_ext     = {2'b00, quo_q};
		q_sgn     = neg_q ? -q_ext : q_ext;
		sum       = zero_q ? PROD_BITS'(a_q) : (PROD_BITS'(a_q) + q_sgn);
		if (sum[PROD_BITS-1]) begin
			res = '0;
		end else if (sum > PROD_BITS'(255)) begin
			res = '1;
		end else begin
			res = sum[COMP_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q     <= a;
			diff_s1 <= DIFF_BITS'({1'b0, b}) - DIFF_BITS'({1'b0, a});
			off_s1  <= OFF_BITS'(x) - OFF_BITS'(lo_pos);
			span_s1 <= OFF_BITS'(hi_pos) - OFF_BITS'(lo_pos);
		end
		if (ctrl.mul) begin
			prod_s2 <= diff_s1 * off_s1;
		end
		if (ctrl.init) begin
			quo_q  <= prod_abs[QUO_BITS-1:0];
			rem_q  <= '0;
			dvs_q  <= span_abs[POS_BITS-1:0];
			neg_q  <= prod_s2[PROD_BITS-1] ^ span_s1[OFF_BITS-1];
			zero_q <= (span_s1 == '0);
		end
		if (ctrl.step) begin
			rem_q <= ge ? trial_sub[POS_BITS-1:0] : trial[POS_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
	end

endmodule
